// ----- rtl/chc_pkg.sv -----
package chc_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned COUNT_W    = 5;
   localparam int unsigned STATUS_W   = 3;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [WORD_W-1:0]  CRC_POLY        = 32'hedb8_8320;
   localparam logic [WORD_W-1:0]  CRC_INIT        = 32'hffff_ffff;
   localparam logic [BYTE_W-1:0]  HDR_VERSION     = 8'd2;
   localparam logic [COUNT_W-1:0] LAST_OFFSET     = 5'd23;
   localparam logic [COUNT_W-1:0] COUNT_MAX       = 5'd31;
   localparam logic [COUNT_W-1:0] MAGIC_LEN       = 5'd8;
   localparam logic [COUNT_W-1:0] CRC_LEN         = 5'd20;

   localparam logic [COUNT_W-1:0] OFS_VERSION    = 5'd8;
   localparam logic [COUNT_W-1:0] OFS_CONSTRAINT = 5'd9;
   localparam logic [COUNT_W-1:0] OFS_RATE_NUM   = 5'd10;
   localparam logic [COUNT_W-1:0] OFS_RATE_DEN   = 5'd11;
   localparam logic [COUNT_W-1:0] OFS_SIZE       = 5'd12;
   localparam logic [COUNT_W-1:0] OFS_PCRC       = 5'd16;
   localparam logic [COUNT_W-1:0] OFS_CHECK      = 5'd20;

   localparam logic [BYTE_W-1:0] MAGIC_BYTES [8] = '{
      8'h4a, 8'h58, 8'h53, 8'h54, 8'h45, 8'h47, 8'h32, 8'h00
   };

   localparam logic [CSR_DATA_W-1:0] CONSTRAINT_RESET = 8'd7;
   localparam logic [CSR_DATA_W-1:0] RATE_NUM_RESET   = 8'd1;
   localparam logic [CSR_DATA_W-1:0] RATE_DEN_RESET   = 8'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CONSTRAINT_HEIGHT = 2'd0,
      CSR_RATE_NUMERATOR    = 2'd1,
      CSR_RATE_DENOMINATOR  = 2'd2
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 3'd0,
      STATUS_WRONG_SIZE = 3'd1,
      STATUS_NOT_CARRIER = 3'd2,
      STATUS_INTEGRITY  = 3'd3,
      STATUS_FORMAT     = 3'd4
   } status_type;

   function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
      logic [WORD_W-1:0] c;
      c = crc ^ {{(WORD_W-BYTE_W){1'b0}}, data};
      for (int k = 0; k < BYTE_W; k++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
      end
      return c;
   endfunction

   function automatic logic [WORD_W-1:0] put_le(input logic [WORD_W-1:0] word,
                                                input logic [1:0] pos,
                                                input logic [BYTE_W-1:0] data);
      logic [WORD_W-1:0] w;
      w = word;
      unique case (pos)
         2'd0: w[7:0]   = data;
         2'd1: w[15:8]  = data;
         2'd2: w[23:16] = data;
         2'd3: w[31:24] = data;
         default: w = word;
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/chc_if.sv -----
interface chc_req_if import chc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] header_byte;
   logic              last_byte;

   modport source (output valid, output header_byte, output last_byte, input ready);
   modport sink   (input valid, input header_byte, input last_byte, output ready);
endinterface

interface chc_rsp_if import chc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [WORD_W-1:0]   body_size;
   logic [WORD_W-1:0]   body_crc;

   modport source (output valid, output status, output body_size, output body_crc,
                   input ready);
   modport sink   (input valid, input status, input body_size, input body_crc,
                   output ready);
endinterface

// ----- rtl/carrier_header_checker_top.sv -----
// A header's verdict is posted on the response channel once its final byte has passed
// the input register and then the result register.
// One header byte is taken per cycle; a waiting verdict stalls input only while the
// next final byte sits in the input register.
// Reset is synchronous and active high; it clears the header state and loads the
// format registers with their default values.
module carrier_header_checker_top import chc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   chc_req_if.sink               req_if,
   chc_rsp_if.source             rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [CSR_DATA_W-1:0] constraint_ff, rate_num_ff, rate_den_ff;

   logic              s1_valid_ff;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_last_ff;

   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [WORD_W-1:0]  crc_ff, crc_in;
   logic               magic_ff, magic_in;
   logic               format_ff, format_in;
   logic [WORD_W-1:0]  size_ff, size_in;
   logic [WORD_W-1:0]  pcrc_ff, pcrc_in;
   logic [WORD_W-1:0]  check_ff, check_in;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [WORD_W-1:0]   rsp_size_ff, rsp_crc_ff;

   status_type status_in;
   logic       out_free;
   logic       s1_fire;
   logic       req_fire;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign s1_fire  = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_if.ready = !s1_valid_ff || s1_fire;
   assign req_fire = req_if.valid && req_if.ready;

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.status    = rsp_status_ff;
   assign rsp_if.body_size = rsp_size_ff;
   assign rsp_if.body_crc  = rsp_crc_ff;

   always_comb begin
      byte_count_in = (byte_count_ff < COUNT_MAX) ? byte_count_ff + 5'd1 : byte_count_ff;
      crc_in    = crc_ff;
      magic_in  = magic_ff;
      format_in = format_ff;
      size_in   = size_ff;
      pcrc_in   = pcrc_ff;
      check_in  = check_ff;

      if (byte_count_ff < MAGIC_LEN && s1_byte_ff != MAGIC_BYTES[byte_count_ff[2:0]]) begin
         magic_in = 1'b0;
      end
      if (byte_count_ff < CRC_LEN) begin
         crc_in = crc_byte(crc_ff, s1_byte_ff);
      end
      if ((byte_count_ff == OFS_VERSION && s1_byte_ff != HDR_VERSION) ||
          (byte_count_ff == OFS_CONSTRAINT && s1_byte_ff != constraint_ff) ||
          (byte_count_ff == OFS_RATE_NUM && s1_byte_ff != rate_num_ff) ||
          (byte_count_ff == OFS_RATE_DEN && s1_byte_ff != rate_den_ff)) begin
         format_in = 1'b0;
      end
      if (byte_count_ff >= OFS_SIZE && byte_count_ff < OFS_PCRC) begin
         size_in = put_le(size_ff, byte_count_ff[1:0], s1_byte_ff);
      end
      if (byte_count_ff >= OFS_PCRC && byte_count_ff < OFS_CHECK) begin
         pcrc_in = put_le(pcrc_ff, byte_count_ff[1:0], s1_byte_ff);
      end
      if (byte_count_ff >= OFS_CHECK && byte_count_ff <= LAST_OFFSET) begin
         check_in = put_le(check_ff, byte_count_ff[1:0], s1_byte_ff);
      end

      priority if (byte_count_ff != LAST_OFFSET) begin
         status_in = STATUS_WRONG_SIZE;
      end else if (!magic_in) begin
         status_in = STATUS_NOT_CARRIER;
      end else if (~crc_in != check_in) begin
         status_in = STATUS_INTEGRITY;
      end else if (!format_in) begin
         status_in = STATUS_FORMAT;
      end else begin
         status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         constraint_ff <= CONSTRAINT_RESET;
         rate_num_ff   <= RATE_NUM_RESET;
         rate_den_ff   <= RATE_DEN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CONSTRAINT_HEIGHT: constraint_ff <= csr_wdata;
            CSR_RATE_NUMERATOR:    rate_num_ff   <= csr_wdata;
            CSR_RATE_DENOMINATOR:  rate_den_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= req_if.valid;
      end
      if (req_fire) begin
         s1_byte_ff <= req_if.header_byte;
         s1_last_ff <= req_if.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (s1_fire && s1_last_ff)) begin
         byte_count_ff <= '0;
         crc_ff        <= CRC_INIT;
         magic_ff      <= 1'b1;
         format_ff     <= 1'b1;
         size_ff       <= '0;
         pcrc_ff       <= '0;
         check_ff      <= '0;
      end else if (s1_fire) begin
         byte_count_ff <= byte_count_in;
         crc_ff        <= crc_in;
         magic_ff      <= magic_in;
         format_ff     <= format_in;
         size_ff       <= size_in;
         pcrc_ff       <= pcrc_in;
         check_ff      <= check_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_fire && s1_last_ff) begin
         rsp_status_ff <= status_in;
         rsp_size_ff   <= (status_in == STATUS_OK) ? size_in : '0;
         rsp_crc_ff    <= (status_in == STATUS_OK) ? pcrc_in : '0;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff == STATUS_OK || rsp_status_ff == STATUS_WRONG_SIZE ||
                        rsp_status_ff == STATUS_NOT_CARRIER ||
                        rsp_status_ff == STATUS_INTEGRITY || rsp_status_ff == STATUS_FORMAT))
      else $error("Response status out of range.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_OK |-> rsp_size_ff == '0 && rsp_crc_ff == '0)
      else $error("Failed verdict carries nonzero payload fields.");

   assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_last_ff |=> byte_count_ff == '0 && rsp_valid_ff)
      else $error("Final byte did not restart the header and post a verdict.");

   assert property (@(posedge clock) disable iff (reset)
      byte_count_ff == '0 |-> crc_ff == CRC_INIT && magic_ff && format_ff)
      else $error("Header state not cleared at the start of a header.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_if.ready && s1_valid_ff && s1_last_ff |-> !s1_fire)
      else $error("Verdict overwritten while the previous one waits.");

endmodule
